@@ rtl/core/ogrid_pkg.sv @@
// Shared types, widths and codes of the occupancy grid block.
package ogrid_pkg;

	localparam int MM_W       = 14;
	localparam int COORD_W    = 16;
	localparam int CODE_W     = 3;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 1;

	localparam int CELL_SIZE_MM_DEF = 100;
	localparam int GRID_WIDTH_DEF   = 128;
	localparam int GRID_HEIGHT_DEF  = 128;

	localparam logic [MM_W-1:0] AREA_WIDTH_RST  = MM_W'(9660);
	localparam logic [MM_W-1:0] AREA_HEIGHT_RST = MM_W'(8930);

	typedef enum logic [MODE_W-1:0] {
		MODE_CLEAR = 2'd0,
		MODE_FILL  = 2'd1,
		MODE_QUERY = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AREA_WIDTH  = 1'b0,
		CFG_AREA_HEIGHT = 1'b1
	} cfg_idx_t;

	localparam logic [CODE_W-1:0] CODE_FREE     = 3'd0;
	localparam logic [CODE_W-1:0] CODE_OBSTACLE = 3'd2;
	localparam logic [CODE_W-1:0] CODE_SHELF    = 3'd3;
	localparam logic [CODE_W-1:0] CODE_WALL     = 3'd4;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CONV,
		ST_ORDER,
		ST_FILL,
		ST_CLEAR,
		ST_READ,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic capture;
		logic convert;
		logic order;
		logic fill_we;
		logic sweep_we;
		logic rd_en;
		logic res_load;
	} cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              fill_ok;
		logic              fill_last;
		logic              sweep_last;
		logic              out_free;
	} status_t;

endpackage

@@ rtl/core/ogrid_if.sv @@
// Handshake channel interfaces for items, results and register writes.
interface ogrid_in_if;
	import ogrid_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [MODE_W-1:0]         mode;
	logic signed [COORD_W-1:0] x_mm;
	logic signed [COORD_W-1:0] y_mm;
	logic signed [COORD_W-1:0] x2_mm;
	logic signed [COORD_W-1:0] y2_mm;
	logic [CODE_W-1:0]         fill_type;

	modport source (output valid, mode, x_mm, y_mm, x2_mm, y2_mm, fill_type, input ready);
	modport sink (input valid, mode, x_mm, y_mm, x2_mm, y2_mm, fill_type, output ready);
endinterface

interface ogrid_out_if;
	import ogrid_pkg::*;
	logic              valid;
	logic              ready;
	logic              in_range;
	logic              blocked;
	logic [CODE_W-1:0] cell_code;

	modport source (output valid, in_range, blocked, cell_code, input ready);
	modport sink (input valid, in_range, blocked, cell_code, output ready);
endinterface

interface ogrid_cfg_if;
	import ogrid_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [MM_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/occupancy_grid_rect_fill_query.sv @@
// Top level of the occupancy grid with rectangle fill and point query.
//
//   Channel  Modport  Transfer
//   in_ch    sink     one command: mode, two corners in mm, fill type
//   out_ch   source   one result per command: in_range, blocked, cell_code
//   cfg      sink     register write: index 0 area width, index 1 area height
//
// A query occupies the block for the transfer, the conversion multiply, the
// registered grid read and the load of the result register. A fill writes each
// cell of the rectangle in turn; a clear writes every grid entry, 2**(clog2(GRID_WIDTH)
// + clog2(GRID_HEIGHT)), over the single write port. After reset the same clearing
// pass runs with in_ch not ready; register writes are taken at any time. A held
// result does not stop the next command from being taken.
module occupancy_grid_rect_fill_query import ogrid_pkg::*; #(
	parameter int CELL_SIZE_MM = CELL_SIZE_MM_DEF,
	parameter int GRID_WIDTH   = GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT  = GRID_HEIGHT_DEF
) (
	input logic         clk,
	input logic         arst_n,
	ogrid_in_if.sink    in_ch,
	ogrid_out_if.source out_ch,
	ogrid_cfg_if.sink   cfg
);

	cmd_t    cmd;
	status_t status;
	logic    in_ready;

	assign in_ch.ready = in_ready;
	assign cfg.ready   = 1'b1;

	ogrid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	ogrid_dp #(
		.CELL_SIZE_MM (CELL_SIZE_MM),
		.GRID_WIDTH   (GRID_WIDTH),
		.GRID_HEIGHT  (GRID_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.mode      (in_ch.mode),
		.x_mm      (in_ch.x_mm),
		.y_mm      (in_ch.y_mm),
		.x2_mm     (in_ch.x2_mm),
		.y2_mm     (in_ch.y2_mm),
		.fill_type (in_ch.fill_type),
		.cfg_valid (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.in_range  (out_ch.in_range),
		.blocked   (out_ch.blocked),
		.cell_code (out_ch.cell_code)
	);

endmodule

@@ rtl/core/ogrid_ctrl.sv @@
// Controller state machine that sequences capture, conversion, fill, clear and query.
module ogrid_ctrl import ogrid_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep_we = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.convert = 1'b1;
				case (status.mode)
					MODE_CLEAR: state_d = ST_CLEAR;
					MODE_FILL:  state_d = ST_ORDER;
					MODE_QUERY: state_d = ST_READ;
					default:    state_d = ST_RESP;
				endcase
			end
			ST_ORDER: begin
				cmd.order = 1'b1;
				state_d   = status.fill_ok ? ST_FILL : ST_RESP;
			end
			ST_FILL: begin
				cmd.fill_we = 1'b1;
				if (status.fill_last) begin
					state_d = ST_RESP;
				end
			end
			ST_CLEAR: begin
				cmd.sweep_we = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_RESP;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_RESP;
			end
			ST_RESP: begin
				if (status.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/ogrid_dp.sv @@
// Datapath: registers, millimetre to cell conversion, grid memory and result register.
module ogrid_dp import ogrid_pkg::*; #(
	parameter int CELL_SIZE_MM = CELL_SIZE_MM_DEF,
	parameter int GRID_WIDTH   = GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT  = GRID_HEIGHT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output status_t                   status,
	input  logic [MODE_W-1:0]         mode,
	input  logic signed [COORD_W-1:0] x_mm,
	input  logic signed [COORD_W-1:0] y_mm,
	input  logic signed [COORD_W-1:0] x2_mm,
	input  logic signed [COORD_W-1:0] y2_mm,
	input  logic [CODE_W-1:0]         fill_type,
	input  logic                      cfg_valid,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [MM_W-1:0]           cfg_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      in_range,
	output logic                      blocked,
	output logic [CODE_W-1:0]         cell_code
);

	localparam int CXW       = $clog2(GRID_WIDTH);
	localparam int CYW       = $clog2(GRID_HEIGHT);
	localparam int AW        = CXW + CYW;
	localparam int DEPTH     = 1 << AW;
	localparam int DIV_SHIFT = MM_W + $clog2(CELL_SIZE_MM) + 1;
	localparam int RECIP     = ((1 << DIV_SHIFT) + CELL_SIZE_MM - 1) / CELL_SIZE_MM;
	localparam int RECIP_W   = MM_W + 3;
	localparam int PROD_W    = DIV_SHIFT + MM_W;
	localparam logic [MM_W:0] X_LIM = (MM_W+1)'(GRID_WIDTH);
	localparam logic [MM_W:0] Y_LIM = (MM_W+1)'(GRID_HEIGHT);

	// Returns the valid flag above the cell index; the division is a
	// multiplication by a rounded-up reciprocal, exact below 2**MM_W.
	function automatic logic [MM_W:0] to_cell(
		input logic signed [COORD_W-1:0] v,
		input logic [MM_W-1:0]           area,
		input logic [MM_W:0]             lim
	);
		logic [PROD_W-1:0] prod;
		logic [MM_W-1:0]   q;
		logic              ok;
		prod = PROD_W'(v[MM_W-1:0]) * PROD_W'(RECIP_W'(RECIP));
		q    = prod[DIV_SHIFT +: MM_W];
		ok   = !v[COORD_W-1] && ({1'b0, v[COORD_W-2:0]} < {2'b00, area})
			&& ({1'b0, q} < lim);
		return {ok, q};
	endfunction

	logic [MM_W-1:0]           area_w_q;
	logic [MM_W-1:0]           area_h_q;
	logic [MODE_W-1:0]         mode_q;
	logic signed [COORD_W-1:0] xa_q, ya_q, xb_q, yb_q;
	logic [CODE_W-1:0]         ftype_q;
	logic [MM_W:0]             cxa, cya, cxb, cyb;
	logic                      ok_a_q, ok_b_q;
	logic [CXW-1:0]            ax_q, bx_q, lo_x_q, hi_x_q, cur_x_q;
	logic [CYW-1:0]            ay_q, by_q, lo_y_q, hi_y_q, cur_y_q;
	logic [AW-1:0]             sweep_q;
	logic [CODE_W-1:0]         mem [DEPTH];
	logic [CODE_W-1:0]         rdata_q;
	logic                      out_valid_q;
	logic                      res_in_range;
	logic                      res_blocked;
	logic [CODE_W-1:0]         res_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_w_q <= AREA_WIDTH_RST;
			area_h_q <= AREA_HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_AREA_WIDTH:  area_w_q <= cfg_data;
				CFG_AREA_HEIGHT: area_h_q <= cfg_data;
				default:         area_w_q <= area_w_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q  <= mode;
			xa_q    <= x_mm;
			ya_q    <= y_mm;
			xb_q    <= x2_mm;
			yb_q    <= y2_mm;
			ftype_q <= fill_type;
		end
	end

	assign cxa = to_cell(xa_q, area_w_q, X_LIM);
	assign cya = to_cell(ya_q, area_h_q, Y_LIM);
	assign cxb = to_cell(xb_q, area_w_q, X_LIM);
	assign cyb = to_cell(yb_q, area_h_q, Y_LIM);

	always_ff @(posedge clk) begin
		if (cmd.convert) begin
			ok_a_q <= cxa[MM_W] && cya[MM_W];
			ok_b_q <= cxb[MM_W] && cyb[MM_W];
			ax_q   <= cxa[CXW-1:0];
			ay_q   <= cya[CYW-1:0];
			bx_q   <= cxb[CXW-1:0];
			by_q   <= cyb[CYW-1:0];
		end
		if (cmd.order) begin
			lo_x_q  <= (ax_q > bx_q) ? bx_q : ax_q;
			hi_x_q  <= (ax_q > bx_q) ? ax_q : bx_q;
			lo_y_q  <= (ay_q > by_q) ? by_q : ay_q;
			hi_y_q  <= (ay_q > by_q) ? ay_q : by_q;
			cur_x_q <= (ax_q > bx_q) ? bx_q : ax_q;
			cur_y_q <= (ay_q > by_q) ? by_q : ay_q;
		end else if (cmd.fill_we) begin
			if (cur_y_q == hi_y_q) begin
				cur_y_q <= lo_y_q;
				cur_x_q <= cur_x_q + CXW'(1);
			end else begin
				cur_y_q <= cur_y_q + CYW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep_we) begin
			sweep_q <= sweep_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_we) begin
			mem[sweep_q] <= CODE_FREE;
		end else if (cmd.fill_we) begin
			mem[{cur_x_q, cur_y_q}] <= ftype_q;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[{ax_q, ay_q}];
		end
	end

	always_comb begin
		res_in_range = 1'b0;
		res_blocked  = 1'b0;
		res_code     = CODE_FREE;
		case (mode_q)
			MODE_CLEAR: begin
				res_in_range = 1'b1;
			end
			MODE_FILL: begin
				res_in_range = ok_a_q && ok_b_q;
			end
			MODE_QUERY: begin
				res_in_range = ok_a_q;
				res_code     = ok_a_q ? rdata_q : CODE_FREE;
				res_blocked  = !ok_a_q || (rdata_q == CODE_OBSTACLE)
					|| (rdata_q == CODE_SHELF) || (rdata_q == CODE_WALL);
			end
			default: begin
				res_in_range = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			in_range  <= res_in_range;
			blocked   <= res_blocked;
			cell_code <= res_code;
		end
	end

	assign out_valid         = out_valid_q;
	assign status.mode       = mode_q;
	assign status.fill_ok    = ok_a_q && ok_b_q;
	assign status.fill_last  = (cur_x_q == hi_x_q) && (cur_y_q == hi_y_q);
	assign status.sweep_last = &sweep_q;
	assign status.out_free   = !out_valid_q || out_ready;

	a_fill_inside: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_we |-> (cur_x_q >= lo_x_q) && (cur_x_q <= hi_x_q)
			&& (cur_y_q >= lo_y_q) && (cur_y_q <= hi_y_q))
		else $error("Fill cursor has left the rectangle.");

	a_order_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.order |=> (lo_x_q <= hi_x_q) && (lo_y_q <= hi_y_q))
		else $error("Rectangle corners are not ordered.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid_q || out_ready))
		else $error("Result loaded over one that has not been transferred.");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.fill_we && cmd.sweep_we))
		else $error("Fill and clear write the grid in the same cycle.");

endmodule
